/* src/euler_to_quaternion_macros.svh */
// assertion helpers shared by the rtl
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// consequent checked in the same cycle
`define E2Q_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("e2q check failed");

// consequent checked in the next cycle
`define E2Q_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("e2q check failed");

`endif

/* src/e2q_pkg.sv */
`timescale 1ns / 1ps
package e2q_pkg;
  // odd taylor-style coefficients of the quarter sine, q28
  localparam logic [28:0] SinC1 = 29'd421657428;
  localparam logic [28:0] SinC3 = 29'd173399667;
  localparam logic [28:0] SinC5 = 29'd21392326;
  localparam logic [28:0] SinC7 = 29'd1256749;
  localparam logic [15:0] SinC9 = 16'd43068;
  localparam logic [15:0] Q15One = 16'd32768;
  // pipeline stages inside the quarter sine unit
  localparam int unsigned SineLat = 6;
  localparam logic signed [17:0] SatMax = 18'sd32767;
  localparam logic signed [17:0] SatMin = -18'sd32768;
endpackage

/* src/e2q_quarter_sine.sv */
`timescale 1ns / 1ps
module e2q_quarter_sine (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] m_i,
  output logic [15:0] sin_o
);
  logic [15:0] z1_q, z2_q, z3_q, z4_q, z5_q;
  logic [15:0] sq1_q, sq2_q, sq3_q, sq4_q;
  logic [28:0] t1_q, t2_q, t3_q, t4_q;
  logic [15:0] sin_q;
  logic [31:0] zz;
  logic [31:0] p1;
  logic [44:0] p2, p3, p4, pf;
  logic [16:0] rnd;

  assign zz  = {16'd0, m_i} * {16'd0, m_i};
  assign p1  = {16'd0, sq1_q} * {16'd0, e2q_pkg::SinC9};
  assign p2  = {29'd0, sq2_q} * {16'd0, t1_q};
  assign p3  = {29'd0, sq3_q} * {16'd0, t2_q};
  assign p4  = {29'd0, sq4_q} * {16'd0, t3_q};
  assign pf  = {29'd0, z5_q} * {16'd0, t4_q};
  // q28 back to q15 with rounding
  assign rnd = 17'((pf[44:15] + 30'd4096) >> 13);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q  <= m_i;
      sq1_q <= zz[30:15];
      z2_q  <= z1_q;
      sq2_q <= sq1_q;
      t1_q  <= e2q_pkg::SinC7 - {12'd0, p1[31:15]} ;
      z3_q  <= z2_q;
      sq3_q <= sq2_q;
      t2_q  <= e2q_pkg::SinC5 - p2[43:15];
      z4_q  <= z3_q;
      sq4_q <= sq3_q;
      t3_q  <= e2q_pkg::SinC3 - p3[43:15];
      z5_q  <= z4_q;
      t4_q  <= e2q_pkg::SinC1 - p4[43:15];
      sin_q <= (rnd > {1'b0, e2q_pkg::Q15One}) ? e2q_pkg::Q15One : rnd[15:0];
    end
  end

  assign sin_o = sin_q;
endmodule

/* src/e2q_quat_combine.sv */
`timescale 1ns / 1ps
module e2q_quat_combine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [2:0]  neg_i,
  input  logic [15:0] sy_mag_i,
  input  logic [15:0] cy_mag_i,
  input  logic [15:0] sp_mag_i,
  input  logic [15:0] cp_mag_i,
  input  logic [15:0] sr_mag_i,
  input  logic [15:0] cr_mag_i,
  output logic        valid_o,
  output logic [15:0] quat_w_o,
  output logic [15:0] quat_x_o,
  output logic [15:0] quat_y_o,
  output logic [15:0] quat_z_o
);
  logic signed [16:0] sy, cy, sp, cp, sr, cr;
  logic signed [33:0] m_cycr, m_sysr, m_cysr, m_sycr;
  logic signed [31:0] cycr_q, sysr_q, cysr_q, sycr_q;
  logic signed [16:0] cp_q, sp_q;
  logic signed [48:0] a0, a1, a2, a3, a4, a5, a6, a7;
  logic signed [46:0] w0_q, w1_q, x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
  logic signed [47:0] sw, sx, sy2, sz;
  logic               v7_q, v8_q, valid_q;
  logic [15:0]        qw_q, qx_q, qy_q, qz_q;

  function automatic logic [15:0] to_q15(input logic signed [47:0] v);
    logic signed [47:0] b;
    logic signed [17:0] r;
    begin
      b = v + 48'sd536870912;
      r = 18'(b >>> 30);
      if (r > e2q_pkg::SatMax) r = e2q_pkg::SatMax;
      if (r < e2q_pkg::SatMin) r = e2q_pkg::SatMin;
      to_q15 = r[15:0];
    end
  endfunction

  assign cy = $signed({1'b0, cy_mag_i});
  assign cp = $signed({1'b0, cp_mag_i});
  assign cr = $signed({1'b0, cr_mag_i});
  assign sy = neg_i[0] ? -$signed({1'b0, sy_mag_i}) : $signed({1'b0, sy_mag_i});
  assign sp = neg_i[1] ? -$signed({1'b0, sp_mag_i}) : $signed({1'b0, sp_mag_i});
  assign sr = neg_i[2] ? -$signed({1'b0, sr_mag_i}) : $signed({1'b0, sr_mag_i});

  assign m_cycr = cy * cr;
  assign m_sysr = sy * sr;
  assign m_cysr = cy * sr;
  assign m_sycr = sy * cr;

  assign a0 = cycr_q * cp_q;
  assign a1 = sysr_q * sp_q;
  assign a2 = cysr_q * cp_q;
  assign a3 = sycr_q * sp_q;
  assign a4 = cycr_q * sp_q;
  assign a5 = sysr_q * cp_q;
  assign a6 = sycr_q * cp_q;
  assign a7 = cysr_q * sp_q;

  assign sw  = 48'(w0_q) + 48'(w1_q);
  assign sx  = 48'(x0_q) - 48'(x1_q);
  assign sy2 = 48'(y0_q) + 48'(y1_q);
  assign sz  = 48'(z0_q) - 48'(z1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v7_q    <= valid_i;
      v8_q    <= v7_q;
      valid_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycr_q <= m_cycr[31:0];
      sysr_q <= m_sysr[31:0];
      cysr_q <= m_cysr[31:0];
      sycr_q <= m_sycr[31:0];
      cp_q   <= cp;
      sp_q   <= sp;
      w0_q   <= a0[46:0];
      w1_q   <= a1[46:0];
      x0_q   <= a2[46:0];
      x1_q   <= a3[46:0];
      y0_q   <= a4[46:0];
      y1_q   <= a5[46:0];
      z0_q   <= a6[46:0];
      z1_q   <= a7[46:0];
      qw_q   <= to_q15(sw);
      qx_q   <= to_q15(sx);
      qy_q   <= to_q15(sy2);
      qz_q   <= to_q15(sz);
    end
  end

  assign valid_o  = valid_q;
  assign quat_w_o = qw_q;
  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;
endmodule

/* src/euler_to_quaternion.sv */
`timescale 1ns / 1ps
// euler angles (z-y-x order) to unit quaternion, q1.15 out
// input channel: in_valid_i / in_ready_o carry one word of yaw, pitch and
//   roll as signed binary angles, 65536 units per full turn
// output channel: out_valid_o / out_ready_i carry one word of quat_w..z
// throughput: one word per cycle, sustained, while the receiver keeps up
// stages from input acceptance to out_valid_o:
//   1 stage folding each angle to magnitude and complement
//   6 stages of the shared-form quarter sine (one multiply per stage)
//   3 stages forming the pair products, the triple products and the
//   rounded, saturated sums
// the latency is set by the horner chain of the quarter sine
// stall: when a result waits and out_ready_i is low the whole pipeline
//   freezes and in_ready_o drops; nothing is lost or repeated
// reset: rst_ni clears every valid bit; payload registers are not reset
// a result of exactly +1.0 saturates to 32767
module euler_to_quaternion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] yaw_angle_i,
  input  logic [15:0] pitch_angle_i,
  input  logic [15:0] roll_angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] quat_w_o,
  output logic [15:0] quat_x_o,
  output logic [15:0] quat_y_o,
  output logic [15:0] quat_z_o
);
  `include "euler_to_quaternion_macros.svh"

  // valid bits of the fold stage and the sine stages
  logic [e2q_pkg::SineLat:0] vld_q;
  logic [2:0]  neg_q [e2q_pkg::SineLat+1];
  logic [15:0] mag_q [3];
  logic [15:0] cmp_q [3];
  logic [15:0] sin_mag [3];
  logic [15:0] cos_mag [3];
  logic [15:0] ang [3];
  logic        en;

  // whole pipeline advances unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign ang[0] = yaw_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = roll_angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[e2q_pkg::SineLat-1:0], in_valid_i};
    end
  end

  // fold: magnitude of the half angle and its complement to a quarter turn
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]   <= ang[i][15] ? 16'(-ang[i]) : ang[i];
        cmp_q[i]   <= e2q_pkg::Q15One - (ang[i][15] ? 16'(-ang[i]) : ang[i]);
        neg_q[0][i] <= ang[i][15];
      end
      for (int k = 1; k <= e2q_pkg::SineLat; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    e2q_quarter_sine u_sin (
      .clk_i (clk_i),
      .en_i  (en),
      .m_i   (mag_q[g]),
      .sin_o (sin_mag[g])
    );
    e2q_quarter_sine u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .m_i   (cmp_q[g]),
      .sin_o (cos_mag[g])
    );
  end

  e2q_quat_combine u_comb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vld_q[e2q_pkg::SineLat]),
    .neg_i    (neg_q[e2q_pkg::SineLat]),
    .sy_mag_i (sin_mag[0]),
    .cy_mag_i (cos_mag[0]),
    .sp_mag_i (sin_mag[1]),
    .cp_mag_i (cos_mag[1]),
    .sr_mag_i (sin_mag[2]),
    .cr_mag_i (cos_mag[2]),
    .valid_o  (out_valid_o),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

  // a frozen pipeline keeps its valid bits
  `E2Q_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_q))
  // a held result keeps the input side closed
  `E2Q_ASSERT_NOW(a_ready_closed, out_valid_o && !out_ready_i, !in_ready_o)
  // a word accepted into the fold stage shows up there next cycle
  `E2Q_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0])
endmodule

/* verif/euler_to_quaternion_tb.sv */
`timescale 1ns / 1ps
module euler_to_quaternion_tb;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } quat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] yaw_angle_i;
  logic [15:0] pitch_angle_i;
  logic [15:0] roll_angle_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] quat_w_o;
  logic [15:0] quat_x_o;
  logic [15:0] quat_y_o;
  logic [15:0] quat_z_o;

  quat_t quat_queue[$];
  int    error_count;
  bit    hold_off;

  euler_to_quaternion i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .yaw_angle_i  (yaw_angle_i),
    .pitch_angle_i(pitch_angle_i),
    .roll_angle_i (roll_angle_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quat_w_o     (quat_w_o),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // quarter-wave sine, q15 magnitude for m in 0..32768
  function automatic longint quarter_sin(longint m);
    longint z2;
    longint t;
    longint s;
    z2 = (m * m) >>> 15;
    t  = e2q_pkg::SinC9;
    t  = e2q_pkg::SinC7 - ((z2 * t) >>> 15);
    t  = e2q_pkg::SinC5 - ((z2 * t) >>> 15);
    t  = e2q_pkg::SinC3 - ((z2 * t) >>> 15);
    t  = e2q_pkg::SinC1 - ((z2 * t) >>> 15);
    s  = (m * t) >>> 15;
    s  = (s + 4096) >>> 13;
    if (s > 32768) s = 32768;
    return s;
  endfunction

  // q45 to q15, round half up, saturate
  function automatic logic [15:0] round_q15(longint v);
    longint r;
    r = (v + (longint'(1) <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t zyx_quat(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    longint a[3];
    longint sn[3];
    longint cs[3];
    longint m;
    quat_t q;
    a[0] = longint'($signed(yaw));
    a[1] = longint'($signed(pitch));
    a[2] = longint'($signed(roll));
    for (int i = 0; i < 3; i++) begin
      m     = (a[i] < 0) ? -a[i] : a[i];
      sn[i] = (a[i] < 0) ? -quarter_sin(m) : quarter_sin(m);
      cs[i] = quarter_sin(32768 - m);
    end
    // index 0 yaw, 1 pitch, 2 roll
    q.w = round_q15(cs[0] * cs[2] * cs[1] + sn[0] * sn[2] * sn[1]);
    q.x = round_q15(cs[0] * sn[2] * cs[1] - sn[0] * cs[2] * sn[1]);
    q.y = round_q15(cs[0] * cs[2] * sn[1] + sn[0] * sn[2] * cs[1]);
    q.z = round_q15(sn[0] * cs[2] * cs[1] - cs[0] * sn[2] * sn[1]);
    return q;
  endfunction

  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    in_valid_i    <= 1'b1;
    yaw_angle_i   <= yaw;
    pitch_angle_i <= pitch;
    roll_angle_i  <= roll;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    quat_queue.push_back(zyx_quat(yaw, pitch, roll));
  endtask

  task automatic idle_input(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(16'h4000 + $urandom_range(0, 3) - 1);
      4: return 16'(16'hc000 + $urandom_range(0, 3) - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] vals[6] = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'hffff};
    for (int i = 0; i < 6; i++) send_angles(vals[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_angles(16'h0000, vals[i], 16'h0000);
    for (int i = 0; i < 6; i++) send_angles(16'h0000, 16'h0000, vals[i]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h1234, 16'h4000, 16'hedcb);
    send_angles(16'h5555, 16'hc000, 16'haaaa);
    idle_input(0);
  endtask

  task automatic test_random(int count);
    int burst;
    for (int n = 0; n < count;) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < count; k++, n++)
        send_angles(rand_angle(), rand_angle(), rand_angle());
      idle_input($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
  endtask

  // receiver blocked for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(60);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    idle_input(0);
  endtask

  task automatic test_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (quat_queue.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern, quiet stretches included
  initial begin
    int mode;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk_i);
        if (hold_off) out_ready_i <= 1'b0;
        else if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else if (mode == 2) out_ready_i <= 1'($urandom_range(0, 1));
        else out_ready_i <= ($urandom_range(0, 5) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    quat_t exp_q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected word w=%h x=%h y=%h z=%h", $time,
                 quat_w_o, quat_x_o, quat_y_o, quat_z_o);
        error_count++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (exp_q.w !== quat_w_o) begin
          $display("%0t: quat_w expected %h actual %h", $time, exp_q.w, quat_w_o);
          error_count++;
        end
        if (exp_q.x !== quat_x_o) begin
          $display("%0t: quat_x expected %h actual %h", $time, exp_q.x, quat_x_o);
          error_count++;
        end
        if (exp_q.y !== quat_y_o) begin
          $display("%0t: quat_y expected %h actual %h", $time, exp_q.y, quat_y_o);
          error_count++;
        end
        if (exp_q.z !== quat_z_o) begin
          $display("%0t: quat_z expected %h actual %h", $time, exp_q.z, quat_z_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int guard;
    error_count   = 0;
    hold_off      = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    yaw_angle_i   = '0;
    pitch_angle_i = '0;
    roll_angle_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800);
    test_backpressure();
    test_drain();
    test_random(960);
    in_valid_i <= 1'b0;
    guard = 0;
    while (quat_queue.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
    if (error_count == 0 && quat_queue.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
